// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the calculator RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define KPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/kpc_pkg.sv =====
// Types and constants shared by the keypad calculator modules.
package kpc_pkg;

  // Operand width and iteration counter width.
  localparam int DataW = 32;
  localparam int CntW  = $clog2(DataW);

  // Key codes.
  localparam logic [7:0] KeyIdle   = 8'd255;
  localparam logic [7:0] KeyAdd    = 8'h2B;
  localparam logic [7:0] KeySub    = 8'h2D;
  localparam logic [7:0] KeyMul    = 8'h58;
  localparam logic [7:0] KeyDiv    = 8'h2F;
  localparam logic [7:0] KeyEq     = 8'h3D;
  localparam logic [7:0] KeyClr    = 8'h43;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [DataW-1:0] Radix = DataW'(10);

  // Width of the packed result word.
  localparam int OutW = 48;

  // Chosen operator codes.
  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4
  } opc_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_NUMBER   = 2'd1,
    KIND_DIV_ZERO = 2'd2,
    KIND_NO_OP    = 2'd3
  } kind_e;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

// ===== rtl/core/kpc_arith_unit.sv =====
// Iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
module kpc_arith_unit
  import kpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alu_req_t         req_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output alu_stat_t        stat_o,
  output logic [DataW-1:0] result_o
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_ADDSUB,
    U_MUL,
    U_ABSA,
    U_ABSB,
    U_DIV,
    U_FIX
  } ustate_e;

  localparam logic [CntW-1:0] CntLast = CntW'(DataW - 1);

  ustate_e          state_q;
  alu_op_e          op_q;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q;
  logic             done_q;
  logic [DataW-1:0] result_q;

  logic [DataW:0]   add_x;
  logic [DataW:0]   add_y;
  logic             add_sub;
  logic [DataW+1:0] add_sum;
  logic             div_ge;

  // Operand selection for the one shared adder.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      U_ADDSUB: begin
        add_x   = {1'b0, a_q};
        add_y   = {1'b0, b_q};
        add_sub = (op_q == ALU_SUB);
      end
      U_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = b_q[0] ? {1'b0, a_q} : '0;
      end
      U_ABSA: begin
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      U_ABSB: begin
        add_y   = {1'b0, b_q};
        add_sub = 1'b1;
      end
      U_DIV: begin
        add_x   = {rem_q, a_q[DataW-1]};
        add_y   = {1'b0, b_q};
        add_sub = 1'b1;
      end
      U_FIX: begin
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  // The adder itself; the top bit is the borrow of a subtraction.
  assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DataW + 2){add_sub}})
                   + {{(DataW + 1){1'b0}}, add_sub};
  assign div_ge  = ~add_sum[DataW+1];

  // Sequencer of the unit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= U_IDLE;
      op_q     <= ALU_ADD;
      a_q      <= '0;
      b_q      <= '0;
      acc_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            a_q   <= a_i;
            b_q   <= b_i;
            acc_q <= '0;
            rem_q <= '0;
            cnt_q <= '0;
            neg_q <= a_i[DataW-1] ^ b_i[DataW-1];
            unique case (req_i.op)
              ALU_ADD, ALU_SUB: state_q <= U_ADDSUB;
              ALU_MUL:          state_q <= U_MUL;
              default:          state_q <= U_ABSA;
            endcase
          end
        end
        U_ADDSUB: begin
          result_q <= add_sum[DataW-1:0];
          done_q   <= 1'b1;
          state_q  <= U_IDLE;
        end
        U_MUL: begin
          // One multiplier bit per cycle, low bits of the product only.
          acc_q <= add_sum[DataW-1:0];
          a_q   <= {a_q[DataW-2:0], 1'b0};
          b_q   <= {1'b0, b_q[DataW-1:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            result_q <= add_sum[DataW-1:0];
            done_q   <= 1'b1;
            state_q  <= U_IDLE;
          end
        end
        U_ABSA: begin
          if (a_q[DataW-1]) begin
            a_q <= add_sum[DataW-1:0];
          end
          state_q <= U_ABSB;
        end
        U_ABSB: begin
          if (b_q[DataW-1]) begin
            b_q <= add_sum[DataW-1:0];
          end
          state_q <= U_DIV;
        end
        U_DIV: begin
          // One quotient bit per cycle; the dividend shifts out as quotient shifts in.
          rem_q <= div_ge ? add_sum[DataW-1:0] : add_x[DataW-1:0];
          a_q   <= {a_q[DataW-2:0], div_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= U_FIX;
          end
        end
        U_FIX: begin
          result_q <= neg_q ? add_sum[DataW-1:0] : a_q;
          done_q   <= 1'b1;
          state_q  <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q != U_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = result_q;

`include "assert_macros.svh"

  `KPC_ASSERT(a_start_idle, req_i.start |-> state_q == U_IDLE, "unit started while busy")
  `KPC_ASSERT(a_done_after_work, done_q |-> $past(state_q) != U_IDLE, "done without work")
  `KPC_ASSERT(a_done_pulse, done_q |=> !done_q, "done held for two cycles")

endmodule

// ===== rtl/core/keypad_four_function_calculator.sv =====
// Sequence: a key that needs no arithmetic goes straight to the output register; '=' with
// an operator runs the shared unit (except divide by zero), and divide adds sign steps before
// and after its loop; a digit runs a multiply by ten in the shared unit, then an add.
// Throughput: one key at a time; the next key is accepted in the cycle after the result is
// loaded, and a stalled result in the output register holds the input off.
// Reset (rst_ni low, asynchronous) clears operands, operator and output and sets entry to the first operand.
// Top level of the keypad calculator: key decode, entry state and result output.
module keypad_four_function_calculator
  import kpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // [7:0] key_code
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // [7:0] echo_char, [8] clear_display,
                                            // [40:9] result_value
  output logic [1:0]      m_axis_tuser_o    // [1:0] result_kind
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ACCUM,
    S_EVAL,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic             fe_q;
  logic             se_q;
  logic             oa_q;
  logic             rs_q;
  logic [DataW-1:0] op1_q;
  logic [DataW-1:0] op2_q;
  opc_e             opc_q;
  logic             tgt_first_q;
  logic [7:0]       pend_key_q;
  logic             pend_clr_q;
  kind_e            pend_kind_q;
  logic [DataW-1:0] pend_val_q;
  logic [DataW-1:0] arg_a_q;
  logic [DataW-1:0] arg_b_q;
  alu_req_t         req_q;
  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;
  kind_e            out_kind_q;

  alu_stat_t        alu_stat;
  logic [DataW-1:0] alu_result;

  logic             in_fire;
  logic [7:0]       key;
  logic             is_cmd;
  logic             fe_c;
  logic             se_c;
  logic             oa_c;
  logic [DataW-1:0] op1_c;
  logic [DataW-1:0] op2_c;
  logic [8:0]       digit_nine;
  logic [DataW-1:0] digit_word;
  logic             out_is_eq;
  logic             out_val_zero;

  // Operator code of an operator key.
  function automatic opc_e op_of(input logic [7:0] k);
    opc_e r;
    r = OPC_NONE;
    priority if (k == KeyAdd) r = OPC_ADD;
    else if (k == KeySub) r = OPC_SUB;
    else if (k == KeyMul) r = OPC_MUL;
    else if (k == KeyDiv) r = OPC_DIV;
    return r;
  endfunction

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign key     = s_axis_tdata_i;
  assign is_cmd  = (key == KeyAdd) || (key == KeySub) || (key == KeyMul) ||
                   (key == KeyDiv) || (key == KeyEq)  || (key == KeyClr);

  // Entry state as seen after the automatic clear that follows a shown result.
  assign fe_c  = rs_q | fe_q;
  assign se_c  = ~rs_q & se_q;
  assign oa_c  = ~rs_q & oa_q;
  assign op1_c = rs_q ? '0 : op1_q;
  assign op2_c = rs_q ? '0 : op2_q;

  // Digit value, code minus 48, sign extended so that low codes wrap.
  assign digit_nine = {1'b0, pend_key_q} - {1'b0, DigitBase};
  assign digit_word = {{(DataW - 9){digit_nine[8]}}, digit_nine};

  // Shared arithmetic unit.
  kpc_arith_unit u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .a_i      (arg_a_q),
    .b_i      (arg_b_q),
    .stat_o   (alu_stat),
    .result_o (alu_result)
  );

  // Key sequencer, entry state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fe_q        <= 1'b1;
      se_q        <= 1'b0;
      oa_q        <= 1'b0;
      rs_q        <= 1'b0;
      op1_q       <= '0;
      op2_q       <= '0;
      opc_q       <= OPC_NONE;
      tgt_first_q <= 1'b1;
      pend_key_q  <= '0;
      pend_clr_q  <= 1'b0;
      pend_kind_q <= KIND_NONE;
      pend_val_q  <= '0;
      arg_a_q     <= '0;
      arg_b_q     <= '0;
      req_q       <= '{start: 1'b0, op: ALU_ADD};
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_kind_q  <= KIND_NONE;
    end else begin
      req_q.start <= 1'b0;
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && key != KeyIdle) begin
            fe_q        <= fe_c;
            se_q        <= se_c;
            oa_q        <= oa_c;
            op1_q       <= op1_c;
            op2_q       <= op2_c;
            rs_q        <= 1'b0;
            pend_key_q  <= key;
            pend_clr_q  <= rs_q;
            pend_kind_q <= KIND_NONE;
            pend_val_q  <= '0;
            state_q     <= S_EMIT;
            if (!is_cmd) begin
              // Digit: scale the active operand by ten in the shared unit.
              if (fe_c) begin
                tgt_first_q <= 1'b1;
                arg_a_q     <= op1_c;
                arg_b_q     <= Radix;
                req_q       <= '{start: 1'b1, op: ALU_MUL};
                oa_q        <= 1'b1;
                state_q     <= S_SCALE;
              end else if (se_c) begin
                tgt_first_q <= 1'b0;
                arg_a_q     <= op2_c;
                arg_b_q     <= Radix;
                req_q       <= '{start: 1'b1, op: ALU_MUL};
                oa_q        <= 1'b0;
                state_q     <= S_SCALE;
              end
            end else if (key == KeyClr) begin
              fe_q       <= 1'b1;
              se_q       <= 1'b0;
              oa_q       <= 1'b0;
              op1_q      <= '0;
              op2_q      <= '0;
              pend_clr_q <= 1'b1;
            end else if (oa_c && key != KeyEq) begin
              // Operator accepted: switch entry to the second operand.
              opc_q <= op_of(key);
              oa_q  <= 1'b0;
              fe_q  <= 1'b0;
              se_q  <= 1'b1;
            end else if (key == KeyEq) begin
              rs_q        <= 1'b1;
              pend_kind_q <= KIND_NUMBER;
              arg_a_q     <= op1_c;
              arg_b_q     <= op2_c;
              if (fe_c && oa_c && !se_c) begin
                pend_val_q <= op1_c;
              end else begin
                unique case (opc_q)
                  OPC_ADD: begin
                    req_q   <= '{start: 1'b1, op: ALU_ADD};
                    state_q <= S_EVAL;
                  end
                  OPC_SUB: begin
                    req_q   <= '{start: 1'b1, op: ALU_SUB};
                    state_q <= S_EVAL;
                  end
                  OPC_MUL: begin
                    req_q   <= '{start: 1'b1, op: ALU_MUL};
                    state_q <= S_EVAL;
                  end
                  OPC_DIV: begin
                    if (op2_c == '0) begin
                      pend_kind_q <= KIND_DIV_ZERO;
                    end else begin
                      req_q   <= '{start: 1'b1, op: ALU_DIV};
                      state_q <= S_EVAL;
                    end
                  end
                  default: begin
                    pend_kind_q <= KIND_NO_OP;
                  end
                endcase
              end
            end
          end
        end
        S_SCALE: begin
          // Add the digit to the scaled operand.
          if (alu_stat.done) begin
            arg_a_q <= alu_result;
            arg_b_q <= digit_word;
            req_q   <= '{start: 1'b1, op: ALU_ADD};
            state_q <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (alu_stat.done) begin
            if (tgt_first_q) begin
              op1_q <= alu_result;
            end else begin
              op2_q <= alu_result;
            end
            state_q <= S_EMIT;
          end
        end
        S_EVAL: begin
          if (alu_stat.done) begin
            pend_val_q <= alu_result;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once it is free.
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {{(OutW - DataW - 9){1'b0}}, pend_val_q, pend_clr_q, pend_key_q};
            out_kind_q  <= pend_kind_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

  // Decoded views of the output register for the checks below.
  assign out_is_eq    = (out_data_q[7:0] == KeyEq);
  assign out_val_zero = (out_data_q[DataW+8:9] == '0);

`include "assert_macros.svh"

  `KPC_ASSERT_NEVER(a_ready_unit_idle, s_axis_tready_o && alu_stat.busy, "ready while unit busy")
  `KPC_ASSERT(a_kind_only_on_eq, out_kind_q != KIND_NONE |-> out_is_eq, "kind without equals key")
  `KPC_ASSERT(a_value_only_number, !out_val_zero |-> out_kind_q == KIND_NUMBER, "value, no number")

endmodule
